// File: rtl/rbnh_pkg.sv
// Shared constants and types of the ray/box nearest-hit unit.
package rbnh_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_INV_DIR_X = 3'd3,
        CFG_INV_DIR_Y = 3'd4,
        CFG_INV_DIR_Z = 3'd5
    } cfg_reg_e;

    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 2 * NUM_AXES;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: rtl/rbnh_ifs.sv
// Valid/ready channel interfaces for boxes in and results out.
interface rbnh_box_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH    = 16
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] box_min_x;
    logic [COORD_WIDTH-1:0] box_min_y;
    logic [COORD_WIDTH-1:0] box_min_z;
    logic [COORD_WIDTH-1:0] box_max_x;
    logic [COORD_WIDTH-1:0] box_max_y;
    logic [COORD_WIDTH-1:0] box_max_z;
    logic [ID_WIDTH-1:0]    object_id;
    logic                   last_box;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z, object_id, last_box,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z, object_id, last_box,
        output ready
    );
endinterface

interface rbnh_res_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH    = 16
);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [COORD_WIDTH-1:0] hit_distance;
    logic                   run_done;
    logic                   nearest_found;
    logic [ID_WIDTH-1:0]    nearest_id;
    logic [COORD_WIDTH-1:0] nearest_distance;

    modport source (
        output valid, hit, hit_distance, run_done, nearest_found,
               nearest_id, nearest_distance,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_distance, run_done, nearest_found,
               nearest_id, nearest_distance,
        output ready
    );
endinterface

// File: rtl/rbnh_front.sv
// Front end: ray registers and the four-stage slab test pipeline.
module rbnh_front
    import rbnh_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int ID_WIDTH    = 16,
    parameter int ENTRY_W     = COORD_WIDTH + ID_WIDTH + 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_idx,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    rbnh_box_if.sink               box,
    input  q_stat_t                q_stat,
    output logic                   push,
    output logic [ENTRY_W-1:0]     push_data
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 1;

    logic signed [W-1:0]  origin_reg  [NUM_AXES];
    logic signed [W-1:0]  inv_dir_reg [NUM_AXES];

    // stage 1: corner minus origin, exact
    logic                 s1_valid_reg;
    logic signed [W:0]    d_reg [NUM_CORNERS];
    logic signed [W:0]    d_next [NUM_CORNERS];
    logic [ID_WIDTH-1:0]  s1_id_reg;
    logic                 s1_last_reg;
    // stage 2: full products
    logic                 s2_valid_reg;
    logic signed [PW-1:0] p_reg [NUM_CORNERS];
    logic signed [PW-1:0] p_next [NUM_CORNERS];
    logic [ID_WIDTH-1:0]  s2_id_reg;
    logic                 s2_last_reg;
    // stage 3: scaled, saturated, sorted per axis
    logic                 s3_valid_reg;
    logic signed [W-1:0]  near_reg [NUM_AXES];
    logic signed [W-1:0]  far_reg  [NUM_AXES];
    logic signed [W-1:0]  near_next [NUM_AXES];
    logic signed [W-1:0]  far_next  [NUM_AXES];
    logic signed [W-1:0]  t_sat [NUM_CORNERS];
    logic [ID_WIDTH-1:0]  s3_id_reg;
    logic                 s3_last_reg;
    // stage 4: interval and hit
    logic                 s4_valid_reg;
    logic                 s4_hit_reg;
    logic [W-1:0]         s4_dist_reg;
    logic [ID_WIDTH-1:0]  s4_id_reg;
    logic                 s4_last_reg;
    logic signed [W-1:0]  tmin, tmax;
    logic                 hit_next;

    logic [W-1:0]         corner [NUM_CORNERS];
    logic                 adv;

    assign adv       = !s4_valid_reg || !q_stat.full;
    assign box.ready = adv;
    assign push      = s4_valid_reg && !q_stat.full;
    assign push_data = {s4_hit_reg, s4_dist_reg, s4_id_reg, s4_last_reg};

    assign corner[0] = box.box_min_x;
    assign corner[1] = box.box_min_y;
    assign corner[2] = box.box_min_z;
    assign corner[3] = box.box_max_x;
    assign corner[4] = box.box_max_y;
    assign corner[5] = box.box_max_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                origin_reg[a]  <= '0;
                inv_dir_reg[a] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_ORIGIN_X:  origin_reg[0]  <= cfg_data;
                CFG_ORIGIN_Y:  origin_reg[1]  <= cfg_data;
                CFG_ORIGIN_Z:  origin_reg[2]  <= cfg_data;
                CFG_INV_DIR_X: inv_dir_reg[0] <= cfg_data;
                CFG_INV_DIR_Y: inv_dir_reg[1] <= cfg_data;
                CFG_INV_DIR_Z: inv_dir_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            d_next[a]            = $signed({corner[a][W-1], corner[a]})
                                 - $signed({origin_reg[a][W-1], origin_reg[a]});
            d_next[a + NUM_AXES] = $signed({corner[a + NUM_AXES][W-1],
                                            corner[a + NUM_AXES]})
                                 - $signed({origin_reg[a][W-1], origin_reg[a]});
            p_next[a]            = d_reg[a] * inv_dir_reg[a];
            p_next[a + NUM_AXES] = d_reg[a + NUM_AXES] * inv_dir_reg[a];
        end
    end

    // floor shift, clamp to the signed coordinate range, then sort near/far per axis
    always_comb
    begin
        logic signed [PW-1:0] sh;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            sh = p_reg[k] >>> FRAC_BITS;
            if (&sh[PW-1:W-1] || ~|sh[PW-1:W-1])
                t_sat[k] = sh[W-1:0];
            else if (sh[PW-1])
                t_sat[k] = {1'b1, {(W-1){1'b0}}};
            else
                t_sat[k] = {1'b0, {(W-1){1'b1}}};
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (t_sat[a] < t_sat[a + NUM_AXES])
            begin
                near_next[a] = t_sat[a];
                far_next[a]  = t_sat[a + NUM_AXES];
            end
            else
            begin
                near_next[a] = t_sat[a + NUM_AXES];
                far_next[a]  = t_sat[a];
            end
        end
    end

    always_comb
    begin
        tmin = near_reg[0];
        tmax = far_reg[0];
        for (int a = 1; a < NUM_AXES; a++)
        begin
            if (near_reg[a] > tmin)
                tmin = near_reg[a];
            if (far_reg[a] < tmax)
                tmax = far_reg[a];
        end
        hit_next = !(tmax[W-1] || (tmin > tmax));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= box.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg       <= d_next;
            s1_id_reg   <= box.object_id;
            s1_last_reg <= box.last_box;
            p_reg       <= p_next;
            s2_id_reg   <= s1_id_reg;
            s2_last_reg <= s1_last_reg;
            near_reg    <= near_next;
            far_reg     <= far_next;
            s3_id_reg   <= s2_id_reg;
            s3_last_reg <= s2_last_reg;
            s4_hit_reg  <= hit_next;
            s4_dist_reg <= hit_next ? tmin : '0;
            s4_id_reg   <= s3_id_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

endmodule

// File: rtl/rbnh_queue.sv
// Small queue of finished slab results between front and back.
module rbnh_queue
    import rbnh_pkg::*;
#(
    parameter int WIDTH = 50,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_stat_t          q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/rbnh_back.sv
// Back end: nearest-hit tracker and result output register.
module rbnh_back
    import rbnh_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH    = 16,
    parameter int ENTRY_W     = COORD_WIDTH + ID_WIDTH + 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  q_stat_t            q_stat,
    input  logic [ENTRY_W-1:0] pop_data,
    output logic               pop,
    rbnh_res_if.source         res
);

    localparam int W = COORD_WIDTH;

    logic                e_hit, e_last;
    logic signed [W-1:0] e_dist;
    logic [ID_WIDTH-1:0] e_id;

    logic                best_valid_reg;
    logic signed [W-1:0] best_distance_reg;
    logic [ID_WIDTH-1:0] best_object_reg;

    logic                out_valid_reg;
    logic                hit_reg, run_done_reg, found_reg;
    logic [W-1:0]        hit_dist_reg, near_dist_reg;
    logic [ID_WIDTH-1:0] near_id_reg;

    logic                upd, found;
    logic signed [W-1:0] cand_dist;
    logic [ID_WIDTH-1:0] cand_id;

    assign {e_hit, e_dist, e_id, e_last} = pop_data;
    assign pop = !q_stat.empty && (!out_valid_reg || res.ready);

    assign upd       = e_hit && (!best_valid_reg || (e_dist < best_distance_reg));
    assign found     = best_valid_reg || upd;
    assign cand_dist = upd ? e_dist : best_distance_reg;
    assign cand_id   = upd ? e_id : best_object_reg;

    assign res.valid            = out_valid_reg;
    assign res.hit              = hit_reg;
    assign res.hit_distance     = hit_dist_reg;
    assign res.run_done         = run_done_reg;
    assign res.nearest_found    = found_reg;
    assign res.nearest_id       = near_id_reg;
    assign res.nearest_distance = near_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            best_valid_reg    <= 1'b0;
            best_distance_reg <= {1'b0, {(W-1){1'b1}}};
            best_object_reg   <= '0;
        end
        else
        begin
            if (pop)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;

            if (pop)
            begin
                if (e_last)
                begin
                    best_valid_reg    <= 1'b0;
                    best_distance_reg <= {1'b0, {(W-1){1'b1}}};
                    best_object_reg   <= '0;
                end
                else if (upd)
                begin
                    best_valid_reg    <= 1'b1;
                    best_distance_reg <= e_dist;
                    best_object_reg   <= e_id;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hit_reg       <= e_hit;
            hit_dist_reg  <= e_dist;
            run_done_reg  <= e_last;
            found_reg     <= e_last && found;
            near_id_reg   <= (e_last && found) ? cand_id : '0;
            near_dist_reg <= (e_last && found) ? cand_dist : '0;
        end
    end

endmodule

// File: rtl/ray_box_nearest_hit_unit.sv
// Top level of the ray/box slab test with nearest-hit tracking.
//
// Boxes enter on the box channel (valid/ready), one word per box: min and max
// corners in signed fixed point, an object id and a last flag. Results leave on
// the res channel, one word per box: hit, entry distance (zero on a miss), and
// on the word of the last box of a cast the nearest hit of that cast.
// The ray (origin and reciprocal direction) sits in six registers written on
// cfg_we/cfg_idx/cfg_data; the user must write them only while the unit is
// idle, as the block itself does not enforce it. Indexes past the list drop.
// Throughput is one box per cycle while box ready is high. A result word
// shows valid after its box passes the difference, product, scale/sort and
// interval stages, the queue write and the pop into the output register.
// A four-entry queue sits between the slab pipeline and the tracker, so a
// stalled receiver first fills the output register and the queue; only then
// does box ready drop, and the pipeline holds in place until room frees up.
// Reset clears the ray registers to zero, empties the pipeline and queue and
// clears the nearest-hit tracker; the first box may arrive the next cycle.
module ray_box_nearest_hit_unit
    import rbnh_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int ID_WIDTH    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_idx,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    rbnh_box_if.sink               box,
    rbnh_res_if.source             res
);

    // queue word: hit, distance, object id, last
    localparam int ENTRY_W = COORD_WIDTH + ID_WIDTH + 2;

    q_stat_t              q_stat;
    logic                 push, pop;
    logic [ENTRY_W-1:0]   push_data, pop_data;

    rbnh_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ID_WIDTH    (ID_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .box       (box),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    rbnh_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // tracker sees words in acceptance order, so "strictly nearest" is exact
    rbnh_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .ID_WIDTH    (ID_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .res      (res)
    );

endmodule
